[rtl/hhr_pkg.sv]
// ----------------------------------------------------------------------------
// hhr_pkg
// Shared constants, types and helpers for the HSV/HSL to RGB converter.
// ----------------------------------------------------------------------------
package hhr_pkg;

  localparam int HUE_STEPS_PER_DEGREE = 16;
  localparam int SECTOR_W             = 60 * HUE_STEPS_PER_DEGREE;

  localparam int HUE_W   = 13;
  localparam int COMP_W  = 8;
  localparam int F_W     = $clog2(2 * SECTOR_W);
  localparam int T_W     = $clog2(SECTOR_W + 1);
  localparam int PROD_W  = 16;
  localparam int AB_W    = 17;
  localparam int NUM_W   = AB_W + T_W;
  localparam int X_W     = NUM_W + 1;
  localparam int DEN2    = 1020 * SECTOR_W;
  localparam int DEN2_W  = $clog2(DEN2 + 1);
  localparam int Q_W     = COMP_W + 1;

  // floor(2^RECIP_SHIFT / DEN2); quotient estimate is exact or one low
  localparam int RECIP_SHIFT = 48;
  localparam int RECIP_W     = RECIP_SHIFT - DEN2_W + 1;
  localparam int MUL_W       = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(DEN2));

  localparam int NUM_CH       = 3;
  localparam int CH_RED       = 0;
  localparam int CH_GREEN     = 1;
  localparam int CH_BLUE      = 2;
  localparam int PIPE_LATENCY = 7;

  localparam logic MODEL_HSV = 1'b0;
  localparam logic MODEL_HSL = 1'b1;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_C,
    SEL_X
  } sel_t;

  typedef sel_t [NUM_CH-1:0] chan_sel_t;

  function automatic chan_sel_t sector_sel(input logic gray, input logic [2:0] sector);
    chan_sel_t s;
    s = {SEL_ZERO, SEL_ZERO, SEL_ZERO};
    if (!gray) begin
      case (sector)
        3'd0: begin s[CH_RED] = SEL_C; s[CH_GREEN] = SEL_X; end
        3'd1: begin s[CH_RED] = SEL_X; s[CH_GREEN] = SEL_C; end
        3'd2: begin s[CH_GREEN] = SEL_C; s[CH_BLUE] = SEL_X; end
        3'd3: begin s[CH_GREEN] = SEL_X; s[CH_BLUE] = SEL_C; end
        3'd4: begin s[CH_RED] = SEL_X; s[CH_BLUE] = SEL_C; end
        default: begin s[CH_RED] = SEL_C; s[CH_BLUE] = SEL_X; end
      endcase
    end
    return s;
  endfunction

endpackage

[rtl/hsv_hsl_to_rgb.sv]
// ----------------------------------------------------------------------------
// hsv_hsl_to_rgb
// Pipelined HSV/HSL to RGB pixel converter with alpha pass-through.
//
// Input: a pixel transfers at a rising edge with start high and busy low.
// busy is high only while rst_n is low; otherwise a pixel may enter every
// cycle. Configuration: cfg_data (0 = HSV, 1 = HSL) is written when
// cfg_valid and cfg_ready are high; cfg_ready is high out of reset.
// Change the model only with the pipeline empty.
// Output: out_valid is high for one cycle per pixel with out_red, out_green,
// out_blue and out_opacity_out; the receiver takes it in that cycle and
// cannot stall. A pixel's valid bit passes through the stage registers
// v1_r to v7_r in order, and out_valid is v7_r. Seven register stages (sector
// decode, product, offset and chroma terms, width scaling, channel sum,
// reciprocal multiply, correction) each take a new pixel every cycle, so
// throughput is one pixel per clock. Reset clears all stage valid bits and
// selects HSV; pixels in flight are dropped. An undefined hue, or hue at or
// past 360 degrees, gives gray.
// ----------------------------------------------------------------------------
module hsv_hsl_to_rgb (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [hhr_pkg::HUE_W-1:0]    in_hue,
  input  logic                         in_hue_defined,
  input  logic [hhr_pkg::COMP_W-1:0]   in_saturation,
  input  logic [hhr_pkg::COMP_W-1:0]   in_level,
  input  logic [hhr_pkg::COMP_W-1:0]   in_alpha,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data,
  output logic                         out_valid,
  output logic [hhr_pkg::COMP_W-1:0]   out_red,
  output logic [hhr_pkg::COMP_W-1:0]   out_green,
  output logic [hhr_pkg::COMP_W-1:0]   out_blue,
  output logic [hhr_pkg::COMP_W-1:0]   out_opacity_out
);

  localparam int W = hhr_pkg::SECTOR_W;

  logic model_r;
  logic accept;

  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_r <= hhr_pkg::MODEL_HSV;
    end else if (cfg_valid && cfg_ready) begin
      model_r <= cfg_data;
    end
  end

  // stage 1: sector, fold, HSL k
  logic [2:0]                  sector;
  logic                        gray;
  logic [hhr_pkg::HUE_W-1:0]   pair_base;
  logic [hhr_pkg::F_W-1:0]     f;
  logic [hhr_pkg::T_W-1:0]     t1_nxt;
  logic [8:0]                  twice;
  logic [8:0]                  lvl_dist;
  logic [hhr_pkg::COMP_W-1:0]  k1_nxt;
  hhr_pkg::chan_sel_t          sel1_nxt;

  always_comb begin
    if (in_hue >= hhr_pkg::HUE_W'(5 * W)) begin
      sector = 3'd5;
    end else if (in_hue >= hhr_pkg::HUE_W'(4 * W)) begin
      sector = 3'd4;
    end else if (in_hue >= hhr_pkg::HUE_W'(3 * W)) begin
      sector = 3'd3;
    end else if (in_hue >= hhr_pkg::HUE_W'(2 * W)) begin
      sector = 3'd2;
    end else if (in_hue >= hhr_pkg::HUE_W'(W)) begin
      sector = 3'd1;
    end else begin
      sector = 3'd0;
    end
    gray = !in_hue_defined || (in_hue >= hhr_pkg::HUE_W'(6 * W));
    case (sector[2:1])
      2'd0:    pair_base = '0;
      2'd1:    pair_base = hhr_pkg::HUE_W'(2 * W);
      default: pair_base = hhr_pkg::HUE_W'(4 * W);
    endcase
    f = hhr_pkg::F_W'(in_hue - pair_base);
    if (f < hhr_pkg::F_W'(W)) begin
      t1_nxt = hhr_pkg::T_W'(f);
    end else begin
      t1_nxt = hhr_pkg::T_W'(hhr_pkg::F_W'(2 * W) - f);
    end
    twice    = {in_level, 1'b0};
    lvl_dist = (twice >= 9'd255) ? (twice - 9'd255) : (9'd255 - twice);
    k1_nxt   = hhr_pkg::COMP_W'(9'd255 - lvl_dist);
    sel1_nxt = hhr_pkg::sector_sel(gray, sector);
  end

  logic                        v1_r, model1_r;
  hhr_pkg::chan_sel_t          sel1_r;
  logic [hhr_pkg::T_W-1:0]     t1_r;
  logic [hhr_pkg::COMP_W-1:0]  sat1_r, lvl1_r, k1_r, alpha1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
    model1_r <= model_r;
    sel1_r   <= sel1_nxt;
    t1_r     <= t1_nxt;
    sat1_r   <= in_saturation;
    lvl1_r   <= in_level;
    k1_r     <= k1_nxt;
    alpha1_r <= in_alpha;
  end

  // stage 2: S*V or S*k
  logic [hhr_pkg::PROD_W-1:0]  prod2_nxt;
  assign prod2_nxt = hhr_pkg::PROD_W'(sat1_r) *
                     hhr_pkg::PROD_W'((model1_r == hhr_pkg::MODEL_HSL) ? k1_r : lvl1_r);

  logic                        v2_r, model2_r;
  hhr_pkg::chan_sel_t          sel2_r;
  logic [hhr_pkg::T_W-1:0]     t2_r;
  logic [hhr_pkg::COMP_W-1:0]  lvl2_r, alpha2_r;
  logic [hhr_pkg::PROD_W-1:0]  prod2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    model2_r <= model1_r;
    sel2_r   <= sel1_r;
    t2_r     <= t1_r;
    lvl2_r   <= lvl1_r;
    alpha2_r <= alpha1_r;
    prod2_r  <= prod2_nxt;
  end

  // stage 3: offset term A and chroma term B, both over 510
  logic [hhr_pkg::AB_W-1:0] lvl510;
  logic [hhr_pkg::AB_W-1:0] a3_nxt, b3_nxt;

  always_comb begin
    lvl510 = hhr_pkg::AB_W'(lvl2_r) * hhr_pkg::AB_W'(510);
    b3_nxt = {prod2_r, 1'b0};
    if (model2_r == hhr_pkg::MODEL_HSL) begin
      a3_nxt = lvl510 - hhr_pkg::AB_W'(prod2_r);
    end else begin
      a3_nxt = lvl510 - b3_nxt;
    end
  end

  logic                        v3_r;
  hhr_pkg::chan_sel_t          sel3_r;
  logic [hhr_pkg::T_W-1:0]     t3_r;
  logic [hhr_pkg::COMP_W-1:0]  alpha3_r;
  logic [hhr_pkg::AB_W-1:0]    a3_r, b3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    sel3_r   <= sel2_r;
    t3_r     <= t2_r;
    alpha3_r <= alpha2_r;
    a3_r     <= a3_nxt;
    b3_r     <= b3_nxt;
  end

  // stage 4: scale by sector width
  logic                        v4_r;
  hhr_pkg::chan_sel_t          sel4_r;
  logic [hhr_pkg::COMP_W-1:0]  alpha4_r;
  logic [hhr_pkg::NUM_W-1:0]   aw4_r, cw4_r, xw4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    sel4_r   <= sel3_r;
    alpha4_r <= alpha3_r;
    aw4_r    <= hhr_pkg::NUM_W'(a3_r) * hhr_pkg::NUM_W'(W);
    cw4_r    <= hhr_pkg::NUM_W'(b3_r) * hhr_pkg::NUM_W'(W);
    xw4_r    <= hhr_pkg::NUM_W'(b3_r) * hhr_pkg::NUM_W'(t3_r);
  end

  // stage 5: rounding numerators 2N + den
  logic [hhr_pkg::X_W-1:0] x5_nxt [hhr_pkg::NUM_CH];
  logic [hhr_pkg::NUM_W-1:0] add5 [hhr_pkg::NUM_CH];

  always_comb begin
    for (int c = 0; c < hhr_pkg::NUM_CH; c++) begin
      case (sel4_r[c])
        hhr_pkg::SEL_C: add5[c] = cw4_r;
        hhr_pkg::SEL_X: add5[c] = xw4_r;
        default:        add5[c] = '0;
      endcase
      x5_nxt[c] = {hhr_pkg::NUM_W'(aw4_r + add5[c]), 1'b0} + hhr_pkg::X_W'(510 * W);
    end
  end

  logic                        v5_r;
  logic [hhr_pkg::COMP_W-1:0]  alpha5_r;
  logic [hhr_pkg::X_W-1:0]     x5_r [hhr_pkg::NUM_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    alpha5_r <= alpha4_r;
    for (int c = 0; c < hhr_pkg::NUM_CH; c++) begin
      x5_r[c] <= x5_nxt[c];
    end
  end

  // stage 6: quotient estimate by reciprocal
  logic [hhr_pkg::MUL_W-1:0] mul6 [hhr_pkg::NUM_CH];

  always_comb begin
    for (int c = 0; c < hhr_pkg::NUM_CH; c++) begin
      mul6[c] = hhr_pkg::MUL_W'(x5_r[c]) * hhr_pkg::MUL_W'(hhr_pkg::RECIP);
    end
  end

  logic                        v6_r;
  logic [hhr_pkg::COMP_W-1:0]  alpha6_r;
  logic [hhr_pkg::X_W-1:0]     x6_r [hhr_pkg::NUM_CH];
  logic [hhr_pkg::Q_W-1:0]     q6_r [hhr_pkg::NUM_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    alpha6_r <= alpha5_r;
    for (int c = 0; c < hhr_pkg::NUM_CH; c++) begin
      x6_r[c] <= x5_r[c];
      q6_r[c] <= mul6[c][hhr_pkg::RECIP_SHIFT +: hhr_pkg::Q_W];
    end
  end

  // stage 7: remainder correction and clamp
  logic [hhr_pkg::X_W-1:0]     rem7 [hhr_pkg::NUM_CH];
  logic [hhr_pkg::Q_W-1:0]     qc7  [hhr_pkg::NUM_CH];
  logic [hhr_pkg::COMP_W-1:0]  ch7_nxt [hhr_pkg::NUM_CH];

  always_comb begin
    for (int c = 0; c < hhr_pkg::NUM_CH; c++) begin
      rem7[c] = x6_r[c] - hhr_pkg::X_W'(hhr_pkg::X_W'(q6_r[c]) *
                                         hhr_pkg::X_W'(hhr_pkg::DEN2));
      qc7[c]  = (rem7[c] >= hhr_pkg::X_W'(hhr_pkg::DEN2)) ? (q6_r[c] + 1'b1) : q6_r[c];
      ch7_nxt[c] = (qc7[c] > hhr_pkg::Q_W'(255)) ? 8'd255 : qc7[c][hhr_pkg::COMP_W-1:0];
    end
  end

  logic                        v7_r;
  logic [hhr_pkg::COMP_W-1:0]  red7_r, green7_r, blue7_r, alpha7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    red7_r   <= ch7_nxt[hhr_pkg::CH_RED];
    green7_r <= ch7_nxt[hhr_pkg::CH_GREEN];
    blue7_r  <= ch7_nxt[hhr_pkg::CH_BLUE];
    alpha7_r <= alpha6_r;
  end

  assign out_valid       = v7_r;
  assign out_red         = red7_r;
  assign out_green       = green7_r;
  assign out_blue        = blue7_r;
  assign out_opacity_out = alpha7_r;

endmodule

[rtl/hhr_checker.sv]
// ----------------------------------------------------------------------------
// hhr_assertions
// Port-level checks for the HSV/HSL to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hhr_assertions (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_hue_defined,
  input logic [hhr_pkg::COMP_W-1:0]  in_alpha,
  input logic                        out_valid,
  input logic [hhr_pkg::COMP_W-1:0]  out_red,
  input logic [hhr_pkg::COMP_W-1:0]  out_green,
  input logic [hhr_pkg::COMP_W-1:0]  out_blue,
  input logic [hhr_pkg::COMP_W-1:0]  out_opacity_out
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(hhr_pkg::PIPE_LATENCY) out_valid)
    else $error("transfer in gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, hhr_pkg::PIPE_LATENCY))
    else $error("result without a transfer in");

  a_alpha_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_opacity_out == $past(in_alpha, hhr_pkg::PIPE_LATENCY)))
    else $error("alpha not passed through");

  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_hue_defined) |-> ##(hhr_pkg::PIPE_LATENCY)
      (out_red == out_green && out_green == out_blue))
    else $error("undefined hue not gray");

endmodule

bind hsv_hsl_to_rgb hhr_assertions u_hhr_assertions (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_hue_defined  (in_hue_defined),
  .in_alpha        (in_alpha),
  .out_valid       (out_valid),
  .out_red         (out_red),
  .out_green       (out_green),
  .out_blue        (out_blue),
  .out_opacity_out (out_opacity_out)
);
